FILE: rtl/rkx_pkg.sv
// Shared types and constants for the rolling-key XOR byte decoder.
package rkx_pkg;

  localparam int unsigned KeyWords = 4;
  localparam int unsigned WordW    = 32;
  localparam int unsigned PosW     = 2;
  localparam int unsigned CfgIdxW  = 3;

  // Configuration register indexes; anything else is ignored.
  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyWord0 = 3'd0,
    CfgKeyWord1 = 3'd1,
    CfgKeyWord2 = 3'd2,
    CfgKeyWord3 = 3'd3
  } cfg_idx_e;

  typedef logic [KeyWords-1:0][WordW-1:0] key_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       start_of_message;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       last_out;
  } out_beat_t;

  // Result of one key step: keystream byte, rolled key, next position.
  typedef struct packed {
    logic [7:0]      ks;
    key_t            key;
    logic [PosW-1:0] pos;
  } step_res_t;

endpackage

FILE: rtl/rkx_keystep.sv
// One step of the rolling key: keystream byte and two-word update.
module rkx_keystep (
  input  rkx_pkg::key_t                 key_i,
  input  logic [rkx_pkg::PosW-1:0]      pos_i,
  output rkx_pkg::step_res_t            res_o
);
  import rkx_pkg::*;

  // Rotate right by 0..7 bits.
  function automatic logic [WordW-1:0] ror_w(logic [WordW-1:0] v, logic [2:0] n);
    logic [2*WordW-1:0] dbl;
    dbl = {v, v} >> n;
    return dbl[WordW-1:0];
  endfunction

  logic [PosW-1:0]  ia;
  logic [PosW-1:0]  ib;
  logic [WordW-1:0] wa;
  logic [WordW-1:0] wb;
  logic [WordW-1:0] wa_new;
  logic [WordW-1:0] wb_new;

  // Select the word pair at the current position.
  assign ia = pos_i;
  assign ib = pos_i + PosW'(1);
  assign wa = key_i[ia];
  assign wb = key_i[ib];

  // Roll a first, then b with the new a.
  assign wa_new = ror_w(wa, wb[2:0]) + WordW'(1);
  assign wb_new = ror_w(wb, wa_new[2:0]) + WordW'(1);

  always_comb begin
    res_o.ks       = wa[7:0] + wb[7:0];
    res_o.key      = key_i;
    res_o.key[ia]  = wa_new;
    res_o.key[ib]  = wb_new;
    res_o.pos      = pos_i + PosW'(1);
  end

endmodule

FILE: rtl/rolling_key_xor_byte_decoder_core.sv
// Top level of the rolling-key XOR byte decoder.
// An input beat passes through the input register, then the result register.
// Throughput: one byte per cycle unless the result beat is stalled; the key update
// is one rotate-add pair per word, done between the input and result registers.
// Reset: asynchronous, active low; clears both stage valids, the key, the position
// and the initial-key registers. No clearing pass.
module rolling_key_xor_byte_decoder_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rkx_pkg::in_beat_t            in_beat_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rkx_pkg::out_beat_t           out_beat_o,
  input  logic                         cfg_we_i,
  input  logic [rkx_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rkx_pkg::WordW-1:0]    cfg_data_i
);
  import rkx_pkg::*;

  key_t            key_init_q;
  key_t            key_q;
  logic [PosW-1:0] pos_q;
  logic            in_valid_q;
  in_beat_t        in_beat_q;
  logic            out_valid_q;
  out_beat_t       out_beat_q;

  logic            out_free;
  logic            advance;
  logic            in_take;
  key_t            key_eff;
  logic [PosW-1:0] pos_eff;
  step_res_t       step;

  // Handshake: the result stage frees when empty or taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_stall_o = in_valid_q && !out_free;

  // Start of message reloads the key and the position.
  assign key_eff = in_beat_q.start_of_message ? key_init_q : key_q;
  assign pos_eff = in_beat_q.start_of_message ? '0 : pos_q;

  rkx_keystep u_step (
    .key_i (key_eff),
    .pos_i (pos_eff),
    .res_o (step)
  );

  // Initial key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_init_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKeyWord0: key_init_q[0] <= cfg_data_i;
        CfgKeyWord1: key_init_q[1] <= cfg_data_i;
        CfgKeyWord2: key_init_q[2] <= cfg_data_i;
        CfgKeyWord3: key_init_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control: stage valids, rolling key and position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      key_q       <= '0;
      pos_q       <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        key_q <= step.key;
        pos_q <= step.pos;
      end
    end
  end

  // Payload: hold the input beat, load the decoded beat.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_beat_q <= in_beat_i;
    end
    if (advance) begin
      out_beat_q.plain_byte <= in_beat_q.cipher_byte ^ step.ks;
      out_beat_q.last_out   <= in_beat_q.end_of_message;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

FILE: rtl/rkx_checker.sv
// Port-level checks for the decoder core, bound to the top level.
module rkx_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rkx_pkg::out_beat_t out_beat_o
);
  import rkx_pkg::*;

  // Hold a stalled result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_beat_o))
    else $error("result beat changed while stalled");

  // Stall input only when a result beat is blocked downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without downstream back-pressure");

  // An accepted beat reaches the result stage when the way is clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 (!out_valid_o || !out_stall_i) |=> out_valid_o)
    else $error("accepted beat did not reach the result stage");

endmodule

bind rolling_key_xor_byte_decoder_core rkx_checker u_rkx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

FILE: dv/rkx_decode_checker.sv
// Checker for the rolling-key XOR byte decoder: predicts each result beat and compares it.
module rkx_decode_checker import rkx_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_beat_t            in_beat_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_beat_t           out_beat_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [WordW-1:0]    cfg_data_i,
  output int                  pending_o,
  output int                  mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the seed registers and of the running key.
  key_t            seed_key = '0;
  key_t            live_key = '0;
  logic [PosW-1:0] live_pos = '0;
  out_beat_t       plain_q[$];
  int              pending_cnt  = 0;
  int              mismatch_cnt = 0;

  assign pending_o    = pending_cnt;
  assign mismatches_o = mismatch_cnt;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] v, input logic [2:0] n);
    logic [2*WordW-1:0] both;
    both = {v, v} >> n;
    return both[WordW-1:0];
  endfunction

  // Decode one byte and roll the two key words it touches.
  function automatic out_beat_t decode_and_roll(input in_beat_t b);
    logic [PosW-1:0]  ia;
    logic [PosW-1:0]  ib;
    logic [WordW-1:0] wa;
    logic [WordW-1:0] wb;
    logic [7:0]       ks;
    out_beat_t        res;
    if (b.start_of_message) begin
      live_key = seed_key;
      live_pos = '0;
    end
    ia = live_pos;
    ib = live_pos + 1'b1;
    wa = live_key[ia];
    wb = live_key[ib];
    ks = wa[7:0] + wb[7:0];
    // the second rotate uses the already updated first word
    wa = rotr(wa, wb[2:0]) + 1'b1;
    wb = rotr(wb, wa[2:0]) + 1'b1;
    live_key[ia] = wa;
    live_key[ib] = wb;
    live_pos = live_pos + 1'b1;
    res.plain_byte = b.cipher_byte ^ ks;
    res.last_out   = b.end_of_message;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      seed_key = '0;
      live_key = '0;
      live_pos = '0;
      plain_q.delete();
    end else begin
      // Compare the result beat with the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (plain_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got byte %02h last %0b",
                   $time, out_beat_i.plain_byte, out_beat_i.last_out);
          mismatch_cnt++;
        end else begin
          want = plain_q.pop_front();
          if (out_beat_i.plain_byte !== want.plain_byte) begin
            $display("%0t: plain_byte mismatch, expected %02h, got %02h",
                     $time, want.plain_byte, out_beat_i.plain_byte);
            mismatch_cnt++;
          end
          if (out_beat_i.last_out !== want.last_out) begin
            $display("%0t: last_out mismatch, expected %0b, got %0b",
                     $time, want.last_out, out_beat_i.last_out);
            mismatch_cnt++;
          end
        end
      end
      // Predict every accepted input beat.
      if (in_valid_i && !in_stall_i) begin
        plain_q.push_back(decode_and_roll(in_beat_i));
      end
      // Track seed writes; out-of-range indexes are dropped.
      if (cfg_we_i && cfg_idx_i < CfgIdxW'(KeyWords)) begin
        seed_key[cfg_idx_i[PosW-1:0]] = cfg_data_i;
      end
    end
    pending_cnt = plain_q.size();
  end

endmodule

FILE: dv/rolling_key_xor_byte_decoder_core_tb.sv
// Testbench top for the rolling-key XOR byte decoder: stimulus, pacing and verdict.
module rolling_key_xor_byte_decoder_core_tb import rkx_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkHalf     = 10;
  localparam int ResetCycles = 12;
  localparam int IdleLimit   = 2000;
  localparam int HoldOff     = 8;
  localparam int TargetBytes = 1550;
  localparam int MaxGap      = 24;

  typedef enum int {StallNone, StallLight, StallPeriodic, StallHeavy} stall_mode_e;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_beat_t           in_beat;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_beat_t          out_beat;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [WordW-1:0]   cfg_data;

  int pending;
  int mismatches;
  int bytes_sent = 0;
  int burst_left = 1;
  int gap_max    = 0;

  rolling_key_xor_byte_decoder_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  rkx_decode_checker u_decode_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_beat_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_beat_i   (out_beat),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  always begin
    clk = 1'b0;
    #(ClkHalf);
    clk = 1'b1;
    #(ClkHalf);
  end

  // Receiver stall: switch to a new random pattern when the current one runs out.
  stall_mode_e stall_mode  = StallNone;
  int          stall_left  = 0;
  int          stall_burst = 4;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode  <= stall_mode_e'($urandom_range(0, 3));
      stall_left  <= $urandom_range(32, 256);
      stall_burst <= $urandom_range(1, 12);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone:     out_stall <= 1'b0;
      StallLight:    out_stall <= ($urandom_range(0, 3) == 0);
      StallPeriodic: out_stall <= ((stall_left % 16) < stall_burst);
      default:       out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog: end the run after too long without any accepted input beat or taken result beat.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold the sender low for a number of cycles.
  task automatic idle_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Present one byte beat and wait until it is taken; gaps fall between bursts.
  task automatic send_byte(input logic [7:0] b, input logic som, input logic eom);
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat  <= '{cipher_byte: b, start_of_message: som, end_of_message: eom};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (gap_max > 0) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        idle_sender($urandom_range(1, gap_max));
      end
    end
  endtask

  task automatic send_message(input int len, input logic with_start, input logic with_end);
    for (int k = 0; k < len; k++) begin
      send_byte(8'($urandom_range(0, 255)), with_start && k == 0, with_end && k == len - 1);
    end
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic drain_results();
    idle_sender(1);
    while (pending != 0) @(negedge clk);
    repeat (HoldOff) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [WordW-1:0] pick_key_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, WordW - 1);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int sel;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_beat  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Decode before any start: the key is all zero and rolls anyway.
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b1);
    drain_results();

    // Load extreme seeds and poke an index that does not exist.
    write_reg(CfgKeyWord0, 32'hFFFF_FFFF);
    write_reg(CfgKeyWord1, 32'h0000_0000);
    write_reg(CfgKeyWord2, 32'h8000_0001);
    write_reg(CfgKeyWord3, 32'h7FFF_FFFE);
    write_reg(CfgIdxW'($urandom_range(KeyWords, 2**CfgIdxW - 1)), $urandom);

    // One message wrapping the word position, then bytes past its end.
    send_byte(8'hFF, 1'b1, 1'b0);
    send_message(5, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h3C, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b0);
    drain_results();

    // New seeds mid-message: the running key keeps going until a start.
    write_reg(CfgKeyWord0, 32'h0000_0007);
    write_reg(CfgKeyWord1, 32'hDEAD_BEEF);
    write_reg(CfgKeyWord2, 32'hFFFF_FF00);
    write_reg(CfgKeyWord3, 32'h0000_00FF);
    send_message(3, 1'b0, 1'b0);
    send_message(5, 1'b1, 1'b1);
    send_byte(8'h81, 1'b1, 1'b1);

    // Random phases: reseed while idle, then mostly well-formed messages.
    while (bytes_sent < TargetBytes) begin
      drain_results();
      repeat ($urandom_range(0, 4)) begin
        write_reg(CfgIdxW'($urandom_range(0, KeyWords - 1)), pick_key_word());
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CfgIdxW'($urandom_range(KeyWords, 2**CfgIdxW - 1)), $urandom);
      end
      gap_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MaxGap);
      burst_left = $urandom_range(1, 16);
      repeat ($urandom_range(2, 6)) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
          send_message($urandom_range(1, 40), 1'b1, 1'b1);
        end else if (sel == 7) begin
          send_message($urandom_range(1, 20), 1'b0, 1'($urandom_range(0, 1)));
        end else if (sel == 8) begin
          send_message($urandom_range(1, 20), 1'b1, 1'b0);
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
          end
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
